@@ rtl/two_stack_queue_top_assert.svh @@
// Assertion macros for the two-stack queue checker.
// Needs no package; the including file supplies clock and reset names.
`ifndef TWO_STACK_QUEUE_TOP_ASSERT_SVH
`define TWO_STACK_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TSQ_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("two_stack_queue check failed: %m");

// Next-cycle implication, disabled while reset is high.
`define TSQ_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("two_stack_queue check failed: %m");

// Next-cycle implication that also holds across reset.
`define TSQ_ASSERT_ALWAYS_NEXT(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("two_stack_queue check failed: %m");

`endif

@@ rtl/tsq_pkg.sv @@
// Shared types and constants for the two-stack queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package tsq_pkg;

  // Entries in each stack.
  localparam int DEPTH = 8;
  // Count width holds 0..DEPTH; index width addresses DEPTH entries.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  // Request kinds carried by the mode input.
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XFER,
    ST_LOAD,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;    // write data_in onto the input stack if it has room
    logic refuse;  // report a refused dequeue
    logic xfer;    // move entries from the input stack to the output stack
    logic pop;     // read the top of the output stack and drop it
    logic load;    // capture the popped value as the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_empty;
    logic out_empty;
    logic xfer_done;
  } stat_t;

endpackage

@@ rtl/tsq_dp.sv @@
// Datapath of the two-stack queue: both stack memories, their counts and
// the result registers. Depends on tsq_pkg.
module tsq_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  tsq_pkg::cmd_t                  cmd,
  input  logic signed [tsq_pkg::DATA_W-1:0] data_in,
  output tsq_pkg::stat_t                 stat,
  output logic                           ok,
  output logic signed [tsq_pkg::DATA_W-1:0] data_out,
  output logic                           is_empty
);

  logic [tsq_pkg::DATA_W-1:0] in_mem  [tsq_pkg::DEPTH];
  logic [tsq_pkg::DATA_W-1:0] out_mem [tsq_pkg::DEPTH];
  logic [tsq_pkg::DATA_W-1:0] in_rd;
  logic [tsq_pkg::DATA_W-1:0] out_rd;
  logic [tsq_pkg::CNT_W-1:0]  in_cnt;
  logic [tsq_pkg::CNT_W-1:0]  out_cnt;
  logic [tsq_pkg::CNT_W-1:0]  in_below;
  logic [tsq_pkg::CNT_W-1:0]  out_below;
  logic                       pend;
  logic                       in_empty;
  logic                       in_full;
  logic                       out_empty;
  logic                       do_push;
  logic                       xfer_rd;
  logic                       xfer_wr;

  // Occupancy flags and the address of each top entry.
  assign in_empty  = (in_cnt == '0);
  assign out_empty = (out_cnt == '0);
  assign in_full   = (in_cnt == tsq_pkg::CNT_W'(tsq_pkg::DEPTH));
  assign in_below  = in_cnt - 1'b1;
  assign out_below = out_cnt - 1'b1;

  // A transfer reads one input entry per cycle and writes it to the output stack in the next cycle.
  assign do_push = cmd.push && !in_full;
  assign xfer_rd = cmd.xfer && !in_empty;
  assign xfer_wr = cmd.xfer && pend;

  // Stack memories with registered reads of the top entries.
  always_ff @(posedge clk) begin
    if (do_push) begin
      in_mem[in_cnt[tsq_pkg::PTR_W-1:0]] <= data_in;
    end
    in_rd <= in_mem[in_below[tsq_pkg::PTR_W-1:0]];
    if (xfer_wr) begin
      out_mem[out_cnt[tsq_pkg::PTR_W-1:0]] <= in_rd;
    end
    out_rd <= out_mem[out_below[tsq_pkg::PTR_W-1:0]];
  end

  // Entry counts and the transfer pipeline flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt  <= '0;
      out_cnt <= '0;
      pend    <= 1'b0;
    end else begin
      pend <= xfer_rd;
      if (do_push) begin
        in_cnt <= in_cnt + 1'b1;
      end else if (xfer_rd) begin
        in_cnt <= in_below;
      end
      if (xfer_wr) begin
        out_cnt <= out_cnt + 1'b1;
      end else if (cmd.pop) begin
        out_cnt <= out_below;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ok       <= !in_full;
      data_out <= '0;
    end else if (cmd.refuse) begin
      ok       <= 1'b0;
      data_out <= '0;
    end else if (cmd.load) begin
      ok       <= 1'b1;
      data_out <= out_rd;
    end
  end

  assign is_empty = in_empty && out_empty;

  assign stat.in_empty  = in_empty;
  assign stat.out_empty = out_empty;
  assign stat.xfer_done = in_empty && !pend;

endmodule

@@ rtl/tsq_ctrl.sv @@
// Controller of the two-stack queue: sequences enqueue, transfer and pop.
// Depends on tsq_pkg; drives the datapath only through cmd_t.
module tsq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           mode,
  input  tsq_pkg::stat_t stat,
  output tsq_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);

  tsq_pkg::state_t state;
  tsq_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      tsq_pkg::ST_IDLE: begin
        if (start) begin
          if (mode == tsq_pkg::MODE_ENQ) begin
            state_next = tsq_pkg::ST_RESP;
          end else if (stat.in_empty && stat.out_empty) begin
            state_next = tsq_pkg::ST_RESP;
          end else if (!stat.out_empty) begin
            state_next = tsq_pkg::ST_LOAD;
          end else begin
            state_next = tsq_pkg::ST_XFER;
          end
        end
      end
      tsq_pkg::ST_XFER: begin
        if (stat.xfer_done) begin
          state_next = tsq_pkg::ST_LOAD;
        end
      end
      tsq_pkg::ST_LOAD: state_next = tsq_pkg::ST_RESP;
      tsq_pkg::ST_RESP: state_next = tsq_pkg::ST_IDLE;
      default:          state_next = tsq_pkg::ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      tsq_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (mode == tsq_pkg::MODE_ENQ) begin
            cmd.push = 1'b1;
          end else if (stat.in_empty && stat.out_empty) begin
            cmd.refuse = 1'b1;
          end else if (!stat.out_empty) begin
            cmd.pop = 1'b1;
          end
        end
      end
      tsq_pkg::ST_XFER: begin
        // Pop in the same cycle the transfer drains.
        cmd.xfer = 1'b1;
        cmd.pop  = stat.xfer_done;
      end
      tsq_pkg::ST_LOAD: cmd.load = 1'b1;
      tsq_pkg::ST_RESP: done = 1'b1;
      default:          busy = 1'b1;
    endcase
  end

endmodule

@@ rtl/two_stack_queue_top.sv @@
// Top level of the two-stack queue: joins the controller and the datapath.
// Depends on tsq_pkg, tsq_ctrl and tsq_dp.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. mode
//   selects enqueue of data_in or dequeue of the oldest value. Each request
//   gives exactly one result: done is high for one cycle with ok, data_out
//   and is_empty valid, and busy stays high until that cycle has ended.
// Controller states, from the accepting edge to the cycle with done high:
//   Enqueue or refused dequeue: straight to ST_RESP.
//   Dequeue with a filled output stack: ST_LOAD, then ST_RESP.
//   Dequeue that first moves N entries: ST_XFER until the move drains,
//   then ST_LOAD and ST_RESP; the move runs one entry per cycle through the
//   registered read port of the input stack.
// Requests do not overlap: the next request is taken at the earliest
//   in the cycle after done.
// Reset: synchronous rst empties both stacks and returns to idle; stack
//   contents need no clearing since only entries below a count are read.
// The receiver cannot stall: each result is flagged by done for one cycle only.
module two_stack_queue_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               mode,
  input  logic signed [tsq_pkg::DATA_W-1:0]  data_in,
  output logic                               busy,
  output logic                               done,
  output logic                               ok,
  output logic signed [tsq_pkg::DATA_W-1:0]  data_out,
  output logic                               is_empty
);

  tsq_pkg::cmd_t  cmd;
  tsq_pkg::stat_t stat;

  // Sequencing.
  tsq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Storage and results.
  tsq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .data_in  (data_in),
    .stat     (stat),
    .ok       (ok),
    .data_out (data_out),
    .is_empty (is_empty)
  );

endmodule

@@ rtl/tsq_chk.sv @@
// Port-level checker for the two-stack queue, bound to the top level.
// Depends on tsq_pkg and two_stack_queue_top_assert.svh.
`include "two_stack_queue_top_assert.svh"

module tsq_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic                              ok,
  input logic signed [tsq_pkg::DATA_W-1:0] data_out
);

  // A result only appears while a request is in flight.
  `TSQ_ASSERT_SAME(a_done_busy, clk, rst, done, busy)
  // An accepted request holds the block busy in the next cycle.
  `TSQ_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // Each result strobe lasts one cycle and frees the block.
  `TSQ_ASSERT_NEXT(a_done_single, clk, rst, done, !done && !busy)
  // A refused request carries zero data.
  `TSQ_ASSERT_SAME(a_refuse_zero, clk, rst, done && !ok, data_out == '0)
  // Reset leaves the block idle with no result pending.
  `TSQ_ASSERT_ALWAYS_NEXT(a_reset_idle, clk, rst, !busy && !done)

endmodule

bind two_stack_queue_top tsq_chk u_tsq_chk (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .ok       (ok),
  .data_out (data_out)
);
